FILE: rtl/assert_macros.svh
// Assertion helpers shared by the queue, front and back RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/bmbs_pkg.sv
package bmbs_pkg;

    localparam logic [2:0]  CMD_BYTES      = 3'd6;
    localparam logic [7:0]  ERASED_BYTE    = 8'hFF;
    localparam logic [16:0] MEM_SIZE_RESET = 17'h10000;
    localparam int          ADDR_LO_BITS   = 3;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // One data-phase access handed from the front to the back
    typedef struct packed {
        logic [31:0] addr;
        logic        is_read;
        logic        oor;
        logic [7:0]  wdata;
    } op_t;

endpackage

FILE: rtl/bmbs_queue.sv
`include "assert_macros.svh"

module bmbs_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bmbs_pkg::op_t  push_op,
    input  logic           pop,
    output bmbs_pkg::op_t  head_op,
    output logic           full,
    output logic           empty
);

    bmbs_pkg::op_t                       entry_reg [bmbs_pkg::QUEUE_DEPTH];
    logic [bmbs_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [bmbs_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [bmbs_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [bmbs_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [bmbs_pkg::QUEUE_PTR_BITS:0]   count_reg;
    logic [bmbs_pkg::QUEUE_PTR_BITS:0]   count_next;

    assign full    = (count_reg == (bmbs_pkg::QUEUE_PTR_BITS+1)'(bmbs_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !empty)

endmodule

FILE: rtl/bmbs_front.sv
`include "assert_macros.svh"

module bmbs_front
#(
    parameter int MEM_ADDR_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [16:0]    cfg_wr_data,
    input  logic           accept,
    input  logic           mode,
    input  logic [7:0]     byte_value,
    output logic           push,
    output bmbs_pkg::op_t  push_op
);

    localparam logic PHASE_CMD  = 1'b0;
    localparam logic PHASE_DATA = 1'b1;

    localparam logic [32:0] STORE_DEPTH = 33'd1 << MEM_ADDR_BITS;

    logic        phase_reg;
    logic        phase_next;
    logic [2:0]  cmd_left_reg;
    logic [2:0]  cmd_left_next;
    logic [47:0] cmd_word_reg;
    logic [47:0] cmd_word_next;
    logic [31:0] addr_reg;
    logic [31:0] addr_next;
    logic [16:0] mem_size_reg;
    logic [32:0] size_ext;
    logic [32:0] limit;

    // Clamp the configured size to the store
    assign size_ext = 33'(mem_size_reg);
    assign limit    = (size_ext > STORE_DEPTH) ? STORE_DEPTH : size_ext;

    always_comb
    begin
        phase_next    = phase_reg;
        cmd_left_next = cmd_left_reg;
        cmd_word_next = cmd_word_reg;
        addr_next     = addr_reg;
        push          = 1'b0;

        push_op.addr    = addr_reg;
        push_op.is_read = cmd_word_reg[47];
        push_op.oor     = ({1'b0, addr_reg} >= limit);
        push_op.wdata   = byte_value;

        if (accept)
        begin
            if (mode)
            begin
                phase_next    = PHASE_CMD;
                cmd_left_next = bmbs_pkg::CMD_BYTES;
            end
            else
            begin
                unique case (phase_reg)
                    PHASE_CMD:
                    begin
                        cmd_word_next = {cmd_word_reg[39:0], byte_value};
                        if (cmd_left_reg != '0)
                        begin
                            cmd_left_next = cmd_left_reg - 1'b1;
                        end
                        if (cmd_left_next == '0)
                        begin
                            addr_next  = {cmd_word_next[44:16],
                                          cmd_word_next[bmbs_pkg::ADDR_LO_BITS-1:0]};
                            phase_next = PHASE_DATA;
                        end
                    end
                    PHASE_DATA:
                    begin
                        push      = 1'b1;
                        addr_next = addr_reg + 32'd1;
                    end
                    default:
                    begin
                        phase_next = PHASE_CMD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_CMD;
            cmd_left_reg <= bmbs_pkg::CMD_BYTES;
            cmd_word_reg <= '0;
            addr_reg     <= '0;
            mem_size_reg <= bmbs_pkg::MEM_SIZE_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            cmd_left_reg <= cmd_left_next;
            cmd_word_reg <= cmd_word_next;
            addr_reg     <= addr_next;
            if (cfg_wr_en)
            begin
                mem_size_reg <= cfg_wr_data;
            end
        end
    end

    `ASSERT_IMPLIES(a_cmd_bytes_pending, clk, rst_n, phase_reg == PHASE_CMD, cmd_left_reg != '0)

endmodule

FILE: rtl/bmbs_back.sv
`include "assert_macros.svh"

module bmbs_back
#(
    parameter int MEM_ADDR_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  bmbs_pkg::op_t  head_op,
    output logic           pop,
    output logic           clear_busy,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output logic [7:0]     read_byte,
    output logic           out_of_range
);

    localparam longint unsigned DEPTH = 64'd1 << MEM_ADDR_BITS;

    logic [7:0]               mem_array [DEPTH];
    logic [7:0]               rd_data_reg;
    logic [MEM_ADDR_BITS:0]   clr_cnt_reg;
    logic                     rd_pend_reg;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic [7:0]               read_byte_reg;
    logic                     oor_reg;
    logic                     mem_we;
    logic                     mem_re;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [7:0]               mem_wdata;

    // Sweep the store with the erased value once after reset
    assign clear_busy = !clr_cnt_reg[MEM_ADDR_BITS];

    assign pop = !q_empty && !rd_pend_reg && !clear_busy && (!rsp_valid_reg || !rsp_stall);

    assign mem_we    = clear_busy || (pop && !head_op.oor && !head_op.is_read);
    assign mem_re    = pop && !head_op.oor && head_op.is_read;
    assign mem_addr  = clear_busy ? clr_cnt_reg[MEM_ADDR_BITS-1:0]
                                  : head_op.addr[MEM_ADDR_BITS-1:0];
    assign mem_wdata = clear_busy ? bmbs_pkg::ERASED_BYTE : head_op.wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem_array[mem_addr];
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rd_pend_reg || (pop && head_op.oor))
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_busy)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            rd_pend_reg   <= mem_re;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Load the result from rd_data_reg while a read is pending, or flag out of range
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            read_byte_reg <= rd_data_reg;
            oor_reg       <= 1'b0;
        end
        else if (pop && head_op.oor)
        begin
            read_byte_reg <= 8'h00;
            oor_reg       <= 1'b1;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign read_byte    = read_byte_reg;
    assign out_of_range = oor_reg;

    `ASSERT_IMPLIES(a_read_slot_free, clk, rst_n, rd_pend_reg, !rsp_valid_reg)
    `ASSERT_NEXT(a_read_lands, clk, rst_n, rd_pend_reg, rsp_valid_reg)

endmodule

FILE: rtl/burst_memory_bus_slave.sv
// Channel   Handshake               Payload
// req       req_valid / req_stall   mode, byte_value
// rsp       rsp_valid / rsp_stall   read_byte, out_of_range
// cfg       cfg_wr_en               cfg_wr_data (mem_size)
//
// Each command byte and each chip-select event is one req transfer; writes and out-of-range
// accesses retire one a cycle while no read is pending and rsp_stall holds no result; a read
// blocks the queue until its byte is in the output register. After reset a clearing pass
// fills all 2^MEM_ADDR_BITS store bytes with 0xFF; req stalls. req also stalls while the
// four-entry access queue is full. A result waits in the output register while rsp_stall is high.

module burst_memory_bus_slave
#(
    parameter int MEM_ADDR_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        mode,
    input  logic [7:0]  byte_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [7:0]  read_byte,
    output logic        out_of_range
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    logic          clear_busy;
    bmbs_pkg::op_t push_op;
    bmbs_pkg::op_t head_op;

    assign req_stall = clear_busy || q_full;
    assign accept    = req_valid && !req_stall;

    bmbs_front
    #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .mode        (mode),
        .byte_value  (byte_value),
        .push        (push),
        .push_op     (push_op)
    );

    bmbs_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    bmbs_back
    #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_op      (head_op),
        .pop          (pop),
        .clear_busy   (clear_busy),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .read_byte    (read_byte),
        .out_of_range (out_of_range)
    );

endmodule
